[design/u8cp_pkg.sv]
// package for the utf-8 to code point decoder
// holds the beat types and the decoding constants; no dependencies
package u8cp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UnitW    = 31;
  localparam int unsigned PendingW = 3;

  localparam logic [UnitW-1:0] SuppStart   = 31'h0001_0000;
  localparam logic [UnitW-1:0] UnicodeMax  = 31'h0010_ffff;
  localparam logic [15:0]      HighOffset  = 16'hd7c0;
  localparam logic [15:0]      LowOffset   = 16'hdc00;
  localparam logic [9:0]       LowMask     = 10'h3ff;

  localparam logic [ByteW-1:0] LeadAscii = 8'h80;
  localparam logic [ByteW-1:0] LeadThree = 8'he0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hf0;
  localparam logic [ByteW-1:0] LeadFive  = 8'hf8;
  localparam logic [ByteW-1:0] LeadSix   = 8'hfc;
  localparam logic [ByteW-1:0] LeadBad   = 8'hfe;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             is_error;
    logic             last_of_run;
    logic             string_done;
  } out_beat_t;

endpackage

[design/utf8_to_code_point_decoder_unit.sv]
// utf-8 to code point decoder, top level
// byte decoding, state registers and a two-beat result buffer; uses u8cp_pkg
//
// usage
//   input channel (in_valid_i, in_stall_o, in_data_i): one byte of a utf-8 string
//   per beat with a last_byte mark. output channel (out_valid_o, out_stall_i,
//   out_data_o): code points, or utf-16 units when utf16_output is set, plus
//   error and end-of-string flags. config channel (cfg_valid_i, cfg_ready_o,
//   cfg_data_i) writes the utf16_output bit, always ready; write it only while
//   the block is idle.
//   a byte is decoded in the cycle it is accepted and its results sit in the
//   result buffer from the next cycle.
//   throughput is one byte per cycle while the output does not stall; a byte that
//   gives a surrogate pair holds the input, as the two-entry result buffer must
//   drain to one entry that is being popped before the next byte is taken.
//   while out_stall_i is high the head result holds and the input stalls as
//   long as any result waits in the buffer.
//   reset clears the decoder state and the config bit and empties the buffer.
module utf8_to_code_point_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8cp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8cp_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned UnitW = u8cp_pkg::UnitW;
  localparam int unsigned PendW = u8cp_pkg::PendingW;

  logic             utf16_q;
  logic [PendW-1:0] pend_q, pend_d;
  logic [UnitW-1:0] pv_q, pv_d;
  logic             skip_q, skip_d;

  u8cp_pkg::out_beat_t ent_q [2];
  u8cp_pkg::out_beat_t ent_d [2];
  logic [1:0]          cnt_q, cnt_d;

  u8cp_pkg::out_beat_t res0, res1;
  logic [1:0]          nres;
  logic                emit, err;
  logic [UnitW-1:0]    cp;
  logic [PendW-1:0]    pend_dec;
  logic [UnitW-1:0]    pv_shift;
  logic [7:0]          b;
  logic                last;
  logic [15:0]         hi_unit, lo_unit;
  logic                pop, accept;

  assign b    = in_data_i.byte_value;
  assign last = in_data_i.last_byte;

  assign pend_dec = pend_q - PendW'(1);
  assign pv_shift = {pv_q[UnitW-7:0], b[5:0]};
  assign hi_unit  = 16'(cp[20:10]) + u8cp_pkg::HighOffset;
  assign lo_unit  = 16'(cp[9:0] & u8cp_pkg::LowMask) + u8cp_pkg::LowOffset;

  always_comb begin
    pend_d = pend_q;
    pv_d   = pv_q;
    skip_d = skip_q;
    emit   = 1'b0;
    err    = 1'b0;
    cp     = '0;
    res0   = '0;
    res1   = '0;
    nres   = 2'd0;

    if (skip_q) begin
      if (last) begin
        skip_d = 1'b0;
      end
    end else if (pend_q != '0) begin
      pend_d = pend_dec;
      pv_d   = pv_shift;
      if (pend_dec == '0) begin
        pv_d = '0;
        emit = 1'b1;
        cp   = pv_shift;
      end else if (last) begin
        err = 1'b1;
      end
    end else begin
      priority if (b < u8cp_pkg::LeadAscii) begin
        emit = 1'b1;
        cp   = UnitW'(b);
      end else if (b < u8cp_pkg::LeadThree) begin
        pend_d = PendW'(1);
        pv_d   = UnitW'(b & 8'h1f);
        err    = last;
      end else if (b < u8cp_pkg::LeadFour) begin
        pend_d = PendW'(2);
        pv_d   = UnitW'(b & 8'h0f);
        err    = last;
      end else if (b < u8cp_pkg::LeadFive) begin
        pend_d = PendW'(3);
        pv_d   = UnitW'(b & 8'h07);
        err    = last;
      end else if (b < u8cp_pkg::LeadSix) begin
        pend_d = PendW'(4);
        pv_d   = UnitW'(b & 8'h03);
        err    = last;
      end else if (b < u8cp_pkg::LeadBad) begin
        pend_d = PendW'(5);
        pv_d   = UnitW'(b & 8'h01);
        err    = last;
      end else begin
        err = 1'b1;
      end
    end

    if (emit) begin
      if (!utf16_q || cp < u8cp_pkg::SuppStart) begin
        res0.code_unit   = cp;
        res0.last_of_run = 1'b1;
        res0.string_done = last;
        nres             = 2'd1;
      end else if (cp <= u8cp_pkg::UnicodeMax) begin
        res0.code_unit   = UnitW'(hi_unit);
        res1.code_unit   = UnitW'(lo_unit);
        res1.last_of_run = 1'b1;
        res1.string_done = last;
        nres             = 2'd2;
      end else begin
        err = 1'b1;
      end
    end

    if (err) begin
      pend_d           = '0;
      pv_d             = '0;
      skip_d           = !last;
      res0             = '0;
      res0.is_error    = 1'b1;
      res0.last_of_run = 1'b1;
      res0.string_done = 1'b1;
      nres             = 2'd1;
    end
  end

  // result buffer
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (accept) begin
      ent_d[0] = res0;
      ent_d[1] = res1;
      cnt_d    = nres;
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf16_q <= 1'b0;
      pend_q  <= '0;
      pv_q    <= '0;
      skip_q  <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        utf16_q <= cfg_data_i;
      end
      if (accept) begin
        pend_q <= pend_d;
        pv_q   <= pv_d;
        skip_q <= skip_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[test/tb.sv]
// self-checking testbench for utf8_to_code_point_decoder_unit
// holds a decode tracker class that predicts units, and byte, stall and mode drivers
// depends on u8cp_pkg and the decoder top level
`timescale 1ns / 1ps

class utf8_unit_tracker;
  logic                          utf16_mode;
  logic [u8cp_pkg::PendingW-1:0] pending;
  logic [u8cp_pkg::UnitW-1:0]    partial;
  logic                          skipping;
  u8cp_pkg::out_beat_t           expected_units[$];
  int unsigned                   n_mismatches;
  int unsigned                   n_bytes;
  int unsigned                   n_units;
  int unsigned                   n_pairs;
  int unsigned                   n_faults;

  function new();
    utf16_mode   = 1'b0;
    pending      = '0;
    partial      = '0;
    skipping     = 1'b0;
    n_mismatches = 0;
    n_bytes      = 0;
    n_units      = 0;
    n_pairs      = 0;
    n_faults     = 0;
  endfunction

  function void set_mode(logic m);
    utf16_mode = m;
  endfunction

  function void push_unit(logic [u8cp_pkg::UnitW-1:0] unit, logic err, logic run_end,
                          logic done);
    u8cp_pkg::out_beat_t u;
    u.code_unit   = unit;
    u.is_error    = err;
    u.last_of_run = run_end;
    u.string_done = done;
    expected_units.insert(expected_units.size(), u);
  endfunction

  function void raise_fault(logic last);
    pending  = '0;
    partial  = '0;
    skipping = !last;
    n_faults++;
    push_unit('0, 1'b1, 1'b1, 1'b1);
  endfunction

  function void emit_point(logic [u8cp_pkg::UnitW-1:0] cp, logic last);
    if (!utf16_mode || cp < u8cp_pkg::SuppStart) begin
      push_unit(cp, 1'b0, 1'b1, last);
    end else if (cp <= u8cp_pkg::UnicodeMax) begin
      n_pairs++;
      push_unit((cp >> 10) + u8cp_pkg::HighOffset, 1'b0, 1'b0, 1'b0);
      push_unit((cp & u8cp_pkg::LowMask) + u8cp_pkg::LowOffset, 1'b0, 1'b1, last);
    end else begin
      raise_fault(last);
    end
  endfunction

  function void note_byte(u8cp_pkg::in_beat_t beat);
    logic [u8cp_pkg::ByteW-1:0] b;
    logic                       last;
    logic [u8cp_pkg::UnitW-1:0] cp;
    b    = beat.byte_value;
    last = beat.last_byte;
    n_bytes++;
    if (skipping) begin
      if (last) skipping = 1'b0;
      return;
    end
    if (pending != 0) begin
      partial = {partial[u8cp_pkg::UnitW-7:0], b[5:0]};
      pending = pending - 1'b1;
      if (pending == 0) begin
        cp      = partial;
        partial = '0;
        emit_point(cp, last);
      end else if (last) begin
        raise_fault(last);
      end
      return;
    end
    if (b < u8cp_pkg::LeadAscii) begin
      emit_point({{(u8cp_pkg::UnitW-u8cp_pkg::ByteW){1'b0}}, b}, last);
      return;
    end
    if (b >= u8cp_pkg::LeadBad) begin
      raise_fault(last);
      return;
    end
    if (b < u8cp_pkg::LeadThree) begin
      pending = 3'd1;
      partial = {26'd0, b[4:0]};
    end else if (b < u8cp_pkg::LeadFour) begin
      pending = 3'd2;
      partial = {27'd0, b[3:0]};
    end else if (b < u8cp_pkg::LeadFive) begin
      pending = 3'd3;
      partial = {28'd0, b[2:0]};
    end else if (b < u8cp_pkg::LeadSix) begin
      pending = 3'd4;
      partial = {29'd0, b[1:0]};
    end else begin
      pending = 3'd5;
      partial = {30'd0, b[0]};
    end
    if (last) raise_fault(last);
  endfunction

  function void check_unit(u8cp_pkg::out_beat_t got);
    u8cp_pkg::out_beat_t want;
    if (expected_units.size() == 0) begin
      $error("unexpected beat: code_unit %h is_error %b", got.code_unit, got.is_error);
      n_mismatches++;
      return;
    end
    want = expected_units.pop_front();
    n_units++;
    if (got.code_unit !== want.code_unit) begin
      $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
      n_mismatches++;
    end
    if (got.is_error !== want.is_error) begin
      $error("is_error: expected %b, got %b", want.is_error, got.is_error);
      n_mismatches++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
      n_mismatches++;
    end
    if (got.string_done !== want.string_done) begin
      $error("string_done: expected %b, got %b", want.string_done, got.string_done);
      n_mismatches++;
    end
  endfunction
endclass

module tb;
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  u8cp_pkg::in_beat_t  in_beat;
  logic                out_valid;
  logic                out_stall;
  u8cp_pkg::out_beat_t out_beat;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;
  logic                quiet;

  utf8_unit_tracker tracker = new();

  utf8_to_code_point_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) tracker.check_unit(out_beat);
      if (in_valid && !in_stall) tracker.note_byte(in_beat);
      if (cfg_valid && cfg_ready) tracker.set_mode(cfg_data);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls in bursts
  initial begin
    int unsigned run_len;
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 8);
      out_stall = 1'b0;
      repeat (run_len) @(negedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_beat.byte_value = b;
    in_beat.last_byte  = last;
    in_valid           = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_string(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.expected_units.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_data  = m;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_string();
    logic [7:0]  bytes[$];
    logic [7:0]  lead;
    int unsigned n_cont;
    int unsigned cls;
    int unsigned cut;
    repeat ($urandom_range(1, 6)) begin
      cls    = $urandom_range(0, 99);
      n_cont = 0;
      if (cls < 30) begin
        lead = 8'($urandom_range(8'h00, 8'h7f));
      end else if (cls < 45) begin
        lead = 8'($urandom_range(8'h80, 8'hdf));
        n_cont = 1;
      end else if (cls < 60) begin
        lead = 8'($urandom_range(8'he0, 8'hef));
        n_cont = 2;
      end else if (cls < 78) begin
        lead = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(8'hf0, 8'hf4))
                                          : 8'($urandom_range(8'hf0, 8'hf7));
        n_cont = 3;
      end else if (cls < 86) begin
        lead = 8'($urandom_range(8'hf8, 8'hfb));
        n_cont = 4;
      end else if (cls < 92) begin
        lead = 8'($urandom_range(8'hfc, 8'hfd));
        n_cont = 5;
      end else if (cls < 96) begin
        lead = 8'($urandom_range(8'hfe, 8'hff));
      end else begin
        lead = 8'($urandom_range(0, 255));
      end
      bytes.insert(bytes.size(), lead);
      repeat (n_cont) begin
        if ($urandom_range(0, 9) == 0) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        else bytes.insert(bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    send_string(bytes);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start;
    start = tracker.n_bytes;
    while (tracker.n_bytes - start < target) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      send_random_string();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid           = 1'b0;
    in_beat.byte_value = '0;
    in_beat.last_byte  = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = 1'b0;
    quiet              = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // code point mode straight after reset
    send_string('{8'h00});
    send_string('{8'h7f});
    send_string('{8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf});
    send_string('{8'hfe, 8'h41, 8'h42});
    send_string('{8'hff});
    send_string('{8'he2});

    // utf-16 mode: top of the range, just above it, top of the bmp, stray continuation lead, truncation
    write_mode(1'b1);
    send_string('{8'hf4, 8'h8f, 8'hbf, 8'hbf});
    send_string('{8'hf4, 8'h90, 8'h80, 8'h80});
    send_string('{8'hef, 8'hbf, 8'hbf});
    send_string('{8'h80, 8'hbf, 8'hc3});

    write_mode(1'b0);
    run_random(350);
    write_mode(1'b1);
    run_random(350);
    write_mode(1'b1);
    run_random(350);
    write_mode(1'b0);
    run_random(350);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d bytes decoded, %0d units checked, %0d surrogate pairs, %0d error units",
             tracker.n_bytes, tracker.n_units, tracker.n_pairs, tracker.n_faults);
    $display("tb: both output modes run with random gaps and stalls on each side");
    if (tracker.n_mismatches == 0 && tracker.expected_units.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

[utf8_to_code_point_decoder_unit.f]
design/u8cp_pkg.sv
design/utf8_to_code_point_decoder_unit.sv
test/tb.sv
